// File: sv/cmwb_pkg.sv
// Package with types and constants shared by the channel to memory word bridge.
`timescale 1ns / 1ps
package cmwb_pkg;

  localparam int BYTES_PER_WORD = 5;
  localparam int IDX_W = $clog2(BYTES_PER_WORD + 1);

  localparam int IN_Q_DEPTH = 4;
  localparam int IN_Q_PTR_W = $clog2(IN_Q_DEPTH);
  localparam int OUT_Q_DEPTH = 2;
  localparam int OUT_Q_PTR_W = $clog2(OUT_Q_DEPTH);

  localparam logic [11:0] FN_READ = 12'o5001;
  localparam logic [11:0] FN_WRITE = 12'o5002;
  localparam logic [11:0] FN_STATUS = 12'o5004;
  localparam logic [11:0] FN_CLEAR = 12'o5010;

  localparam logic [5:0] ST_ABORT = 6'o01;
  localparam logic [5:0] ST_ACCEPT = 6'o02;

  localparam int BIT_READ_ONE = 21;
  localparam int BIT_FLAG = 23;

  typedef enum logic [1:0] {
    ACT_FUNCTION = 2'd0,
    ACT_BYTE     = 2'd1,
    ACT_POLL     = 2'd2,
    ACT_REPLY    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    K_FN_READ   = 3'd0,
    K_FN_WRITE  = 3'd1,
    K_FN_STATUS = 3'd2,
    K_FN_CLEAR  = 3'd3,
    K_FN_BAD    = 3'd4,
    K_BYTE      = 3'd5,
    K_POLL      = 3'd6,
    K_REPLY     = 3'd7
  } item_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_READ   = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_STATUS = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    RK_FUNC_REPLY = 2'd0,
    RK_HOST_BYTE  = 2'd1,
    RK_MEM_REQ    = 2'd2,
    RK_DEACTIVATE = 2'd3
  } result_kind_t;

  typedef enum logic [1:0] {
    RC_ACCEPTED  = 2'd0,
    RC_PROCESSED = 2'd1,
    RC_DECLINED  = 2'd2
  } reply_code_t;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLAG  = 2'd2
  } mem_op_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] chan_byte;
    logic        mem_ok;
    logic [59:0] mem_rdata;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  reply_code;
    logic [11:0] out_byte;
    logic        disconnect_after;
    logic [1:0]  mem_op;
    logic [23:0] mem_addr;
    logic [59:0] mem_wdata;
  } out_item_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [11:0] chan_byte;
    logic        mem_ok;
    logic [59:0] mem_rdata;
  } cls_item_t;

endpackage

// File: sv/cmwb_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module cmwb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  cmwb_pkg::in_item_t  in_item,
  output logic                q_valid,
  input  logic                q_pop,
  output cmwb_pkg::cls_item_t q_item
);

  cmwb_pkg::cls_item_t mem_r [cmwb_pkg::IN_Q_DEPTH];
  logic [cmwb_pkg::IN_Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [cmwb_pkg::IN_Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [cmwb_pkg::IN_Q_PTR_W:0] count_r, count_nxt;
  cmwb_pkg::cls_item_t cls;
  logic do_push;
  logic do_pop;

  always_comb begin
    cls.chan_byte = in_item.chan_byte;
    cls.mem_ok = in_item.mem_ok;
    cls.mem_rdata = in_item.mem_rdata;
    case (in_item.action)
      cmwb_pkg::ACT_FUNCTION: begin
        case (in_item.chan_byte)
          cmwb_pkg::FN_READ: cls.kind = cmwb_pkg::K_FN_READ;
          cmwb_pkg::FN_WRITE: cls.kind = cmwb_pkg::K_FN_WRITE;
          cmwb_pkg::FN_STATUS: cls.kind = cmwb_pkg::K_FN_STATUS;
          cmwb_pkg::FN_CLEAR: cls.kind = cmwb_pkg::K_FN_CLEAR;
          default: cls.kind = cmwb_pkg::K_FN_BAD;
        endcase
      end
      cmwb_pkg::ACT_BYTE: cls.kind = cmwb_pkg::K_BYTE;
      cmwb_pkg::ACT_POLL: cls.kind = cmwb_pkg::K_POLL;
      default: cls.kind = cmwb_pkg::K_REPLY;
    endcase
  end

  assign full = (count_r == (cmwb_pkg::IN_Q_PTR_W + 1)'(cmwb_pkg::IN_Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: sv/cmwb_back.sv
// Back end: carries out queued items against the bridge state and forms results.
`timescale 1ns / 1ps
module cmwb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cmwb_pkg::cls_item_t q_item,
  output logic                q_pop,
  input  logic                res_full,
  output logic                res_valid,
  output cmwb_pkg::out_item_t res_item
);

  localparam logic [cmwb_pkg::IDX_W-1:0] BPW =
    cmwb_pkg::IDX_W'(cmwb_pkg::BYTES_PER_WORD);

  cmwb_pkg::mode_t mode_r, mode_nxt;
  logic [59:0] buf_r, buf_nxt;
  logic [23:0] addr_r, addr_nxt;
  logic [1:0] abs_r, abs_nxt;
  logic [cmwb_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic fetch_r, fetch_nxt;
  logic await_r, await_nxt;
  logic [5:0] status_r, status_nxt;
  logic disc_r, disc_nxt;
  logic fire;

  assign fire = q_valid && !res_full;
  assign q_pop = fire;

  always_comb begin
    logic send;
    logic [cmwb_pkg::IDX_W-1:0] idx_inc;
    mode_nxt = mode_r;
    buf_nxt = buf_r;
    addr_nxt = addr_r;
    abs_nxt = abs_r;
    idx_nxt = idx_r;
    fetch_nxt = fetch_r;
    await_nxt = await_r;
    status_nxt = status_r;
    disc_nxt = disc_r;
    res_valid = 1'b0;
    res_item = '0;
    send = 1'b0;
    case (q_item.kind)
      cmwb_pkg::K_FN_READ, cmwb_pkg::K_FN_WRITE, cmwb_pkg::K_FN_STATUS: begin
        abs_nxt = '0;
        idx_nxt = '0;
        addr_nxt = '0;
        fetch_nxt = 1'b0;
        await_nxt = 1'b0;
        disc_nxt = 1'b0;
        if (q_item.kind == cmwb_pkg::K_FN_READ) begin
          mode_nxt = cmwb_pkg::MODE_READ;
        end else if (q_item.kind == cmwb_pkg::K_FN_WRITE) begin
          mode_nxt = cmwb_pkg::MODE_WRITE;
        end else begin
          mode_nxt = cmwb_pkg::MODE_STATUS;
        end
        res_valid = 1'b1;
        res_item.result_kind = cmwb_pkg::RK_FUNC_REPLY;
        res_item.reply_code = cmwb_pkg::RC_ACCEPTED;
      end
      cmwb_pkg::K_FN_CLEAR: begin
        mode_nxt = cmwb_pkg::MODE_IDLE;
        status_nxt = cmwb_pkg::ST_ACCEPT;
        await_nxt = 1'b0;
        disc_nxt = 1'b0;
        res_valid = 1'b1;
        res_item.result_kind = cmwb_pkg::RK_FUNC_REPLY;
        res_item.reply_code = cmwb_pkg::RC_PROCESSED;
      end
      cmwb_pkg::K_FN_BAD: begin
        res_valid = 1'b1;
        res_item.result_kind = cmwb_pkg::RK_FUNC_REPLY;
        res_item.reply_code = cmwb_pkg::RC_DECLINED;
      end
      cmwb_pkg::K_REPLY: begin
        if (await_r) begin
          await_nxt = 1'b0;
          if (mode_r == cmwb_pkg::MODE_WRITE) begin
            if (q_item.mem_ok) begin
              idx_nxt = '0;
              addr_nxt = addr_r + 24'd1;
            end else begin
              status_nxt = cmwb_pkg::ST_ABORT;
              res_valid = 1'b1;
              res_item.result_kind = cmwb_pkg::RK_DEACTIVATE;
            end
          end else if (mode_r == cmwb_pkg::MODE_READ) begin
            if (q_item.mem_ok) begin
              status_nxt = cmwb_pkg::ST_ACCEPT;
            end else begin
              status_nxt = cmwb_pkg::ST_ABORT;
              disc_nxt = 1'b1;
            end
            idx_nxt = '0;
            if (fetch_r) begin
              if (q_item.mem_ok) begin
                buf_nxt = q_item.mem_rdata;
              end
              fetch_nxt = 1'b0;
              send = 1'b1;
            end else begin
              buf_nxt = '0;
            end
          end
        end
      end
      default: begin
        if (!await_r) begin
          if (mode_r == cmwb_pkg::MODE_STATUS) begin
            if (q_item.kind == cmwb_pkg::K_POLL) begin
              mode_nxt = cmwb_pkg::MODE_IDLE;
              res_valid = 1'b1;
              res_item.result_kind = cmwb_pkg::RK_HOST_BYTE;
              res_item.out_byte = {6'd0, status_r};
            end
          end else if (mode_r != cmwb_pkg::MODE_IDLE) begin
            if (abs_r != 2'd2) begin
              if (q_item.kind == cmwb_pkg::K_BYTE) begin
                addr_nxt = {addr_r[11:0], q_item.chan_byte};
                abs_nxt = abs_r + 2'd1;
                if (abs_r == 2'd1 && mode_r == cmwb_pkg::MODE_READ) begin
                  if (addr_nxt[cmwb_pkg::BIT_FLAG]) begin
                    fetch_nxt = 1'b0;
                    await_nxt = 1'b1;
                    res_valid = 1'b1;
                    res_item.result_kind = cmwb_pkg::RK_MEM_REQ;
                    res_item.mem_op = cmwb_pkg::OP_FLAG;
                    res_item.mem_addr = addr_nxt;
                  end else begin
                    fetch_nxt = 1'b1;
                  end
                end
              end
            end else if (mode_r == cmwb_pkg::MODE_READ) begin
              if (q_item.kind == cmwb_pkg::K_POLL) begin
                if (fetch_r) begin
                  await_nxt = 1'b1;
                  res_valid = 1'b1;
                  res_item.result_kind = cmwb_pkg::RK_MEM_REQ;
                  res_item.mem_op = cmwb_pkg::OP_READ;
                  res_item.mem_addr = addr_r;
                end else begin
                  send = 1'b1;
                end
              end
            end else if (q_item.kind == cmwb_pkg::K_BYTE) begin
              status_nxt = cmwb_pkg::ST_ACCEPT;
              buf_nxt = {buf_r[47:0], q_item.chan_byte};
              if (idx_r < BPW) begin
                idx_nxt = idx_r + 1'b1;
                if (idx_nxt == BPW) begin
                  await_nxt = 1'b1;
                  res_valid = 1'b1;
                  res_item.result_kind = cmwb_pkg::RK_MEM_REQ;
                  res_item.mem_op = cmwb_pkg::OP_WRITE;
                  res_item.mem_addr = addr_r;
                  res_item.mem_wdata = buf_nxt;
                end
              end
            end
          end
        end
      end
    endcase
    if (send) begin
      idx_inc = idx_nxt + 1'b1;
      res_valid = 1'b1;
      res_item.result_kind = cmwb_pkg::RK_HOST_BYTE;
      res_item.out_byte = buf_nxt[59:48];
      buf_nxt = {buf_nxt[47:0], 12'd0};
      if (idx_inc >= BPW) begin
        if (addr_r[cmwb_pkg::BIT_READ_ONE] || addr_r[cmwb_pkg::BIT_FLAG]) begin
          disc_nxt = 1'b1;
        end
        fetch_nxt = 1'b1;
        idx_nxt = '0;
        addr_nxt = addr_r + 24'd1;
      end else begin
        idx_nxt = idx_inc;
      end
      res_item.disconnect_after = disc_nxt;
      disc_nxt = 1'b0;
    end else begin
      idx_inc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cmwb_pkg::MODE_IDLE;
      buf_r <= '0;
      addr_r <= '0;
      abs_r <= '0;
      idx_r <= '0;
      fetch_r <= 1'b0;
      await_r <= 1'b0;
      status_r <= cmwb_pkg::ST_ACCEPT;
      disc_r <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      buf_r <= buf_nxt;
      addr_r <= addr_nxt;
      abs_r <= abs_nxt;
      idx_r <= idx_nxt;
      fetch_r <= fetch_nxt;
      await_r <= await_nxt;
      status_r <= status_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

// File: sv/cmwb_outq.sv
// Result queue: holds finished result items until the consumer pops them.
`timescale 1ns / 1ps
module cmwb_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  input  logic                wr_en,
  input  cmwb_pkg::out_item_t wr_item,
  output logic                q_full,
  output logic                empty,
  input  logic                pop,
  output cmwb_pkg::out_item_t out_item
);

  cmwb_pkg::out_item_t mem_r [cmwb_pkg::OUT_Q_DEPTH];
  logic [cmwb_pkg::OUT_Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [cmwb_pkg::OUT_Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [cmwb_pkg::OUT_Q_PTR_W:0] count_r, count_nxt;
  logic do_push;
  logic do_pop;

  assign q_full = (count_r == (cmwb_pkg::OUT_Q_PTR_W + 1)'(cmwb_pkg::OUT_Q_DEPTH));
  assign empty = (count_r == '0);
  assign out_item = mem_r[rd_ptr_r];
  assign do_push = wr_en && wr_valid;
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// File: sv/channel_to_memory_word_bridge_unit.sv
// Top level of the channel to memory word bridge.
// The bridge takes one item per clock cycle while full is low. An accepted item
// lands in a four-entry input queue; the back end carries out one item per cycle
// from it while the result queue is not full, writing any result to a two-entry
// result queue; an item is registered in the input queue, its result then in
// the result queue. One back-end state update per cycle sets the rate; full rises
// only when the result side has stalled long enough to fill both queues.
`timescale 1ns / 1ps
module channel_to_memory_word_bridge_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  cmwb_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output cmwb_pkg::out_item_t out_item
);

  logic q_valid;
  logic q_pop;
  cmwb_pkg::cls_item_t q_item;
  logic res_valid;
  logic res_full;
  cmwb_pkg::out_item_t res_item;

  cmwb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  cmwb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_full  (res_full),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  cmwb_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (res_valid),
    .wr_en    (q_pop),
    .wr_item  (res_item),
    .q_full   (res_full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
